@@ src/mrg_pkg.sv @@
// Package for the multiply-xor random generator.
// Holds the word types, item and width codes, constants and the seed update
// functions. No dependencies.
`default_nettype none

package mrg_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned CntW  = 6;

  localparam logic [DataW-1:0] XOR_IN_CONST  = 64'h5c6d7e8f90a1b2c3;
  localparam logic [DataW-1:0] MUL_CONST     = 64'h93a4b5c6d7e8f90b;
  localparam logic [DataW-1:0] ADD_CONST     = 64'h15263748596a7b8c;
  localparam logic [DataW-1:0] XOR_OUT_CONST = 64'hc3b2a1908f7e6d5c;

  // Bit positions exchanged by the uniform update.
  localparam int unsigned SwapAHi = 44;
  localparam int unsigned SwapALo = 12;
  localparam int unsigned SwapBHi = 32;
  localparam int unsigned SwapBLo = 0;

  // Item kinds.
  localparam logic [1:0] KIND_DRAW = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Result width codes.
  localparam logic [2:0] WC_BIT  = 3'd0;
  localparam logic [2:0] WC_BYTE = 3'd1;
  localparam logic [2:0] WC_HALF = 3'd2;
  localparam logic [2:0] WC_WORD = 3'd3;

  // Update modes.
  localparam logic MODE_UNIFORM = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [DataW-1:0] seed_value;
    logic [2:0]       width_code;
    logic [DataW-1:0] range_low;
    logic [DataW-1:0] range_high;
  } in_word_t;

  typedef struct packed {
    logic [DataW-1:0] random_value;
    logic [DataW-1:0] ranged_value;
    logic             range_error;
  } out_word_t;

  // Mask that keeps the selected number of low bits; codes above the
  // 32-bit code select the full word.
  function automatic logic [DataW-1:0] width_mask(input logic [2:0] code);
    logic [DataW-1:0] m;
    unique case (code)
      WC_BIT:  m = 64'h0000_0000_0000_0001;
      WC_BYTE: m = 64'h0000_0000_0000_00ff;
      WC_HALF: m = 64'h0000_0000_0000_ffff;
      WC_WORD: m = 64'h0000_0000_ffff_ffff;
      default: m = '1;
    endcase
    return m;
  endfunction

  // Finishing step of the seed update, applied to the product.
  function automatic logic [DataW-1:0] post_update(input logic [DataW-1:0] s,
                                                   input logic mode);
    logic [DataW-1:0] t;
    if (mode == MODE_UNIFORM) begin
      t          = s;
      t[SwapAHi] = s[SwapALo];
      t[SwapALo] = s[SwapAHi];
      t[SwapBHi] = s[SwapBLo];
      t[SwapBLo] = s[SwapBHi];
    end else begin
      t = (s + ADD_CONST) ^ XOR_OUT_CONST;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

@@ src/mulxor_random_generator.sv @@
// Top level of the multiply-xor random generator.
// Depends on mrg_pkg, mrg_mul and mrg_div.
//
// Usage:
//   Input: a word on in_data is taken at a rising edge where start is high
//   and busy is low. Kinds: draw (advance the seed), load seed, read seed.
//   Output: one result word per input word, on out_data for a single cycle
//   while out_valid is high. The receiver cannot hold results off, so no
//   result is ever stalled.
//   Configuration: cfg_we with cfg_wdata writes the update mode (0 uniform
//   with bit swaps, 1 cyclic add-xor); write it only while the block is idle.
// Timing:
//   Load or read: the result is registered at acceptance; busy never rises, so a
//   new word may follow every cycle.
//   Draw with an empty range: result from the bit-serial constant multiplier.
//   Draw with a valid range: the multiplier followed by the radix-2 modulo
//   unit, one bit per cycle each.
//   The next word is taken in the cycle the result appears.
// Reset: synchronous active-low rst_n clears the seed and the mode to zero
//   and drops any draw in progress.
`default_nettype none

module mulxor_random_generator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire mrg_pkg::in_word_t  in_data,
  output logic                    out_valid,
  output mrg_pkg::out_word_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata
);
  import mrg_pkg::*;

  state_t           state_r, state_nxt;
  logic             mode_r;
  logic [DataW-1:0] seed_r;
  logic [2:0]       width_r;
  logic [DataW-1:0] low_r;
  logic [DataW-1:0] high_r;
  logic [DataW-1:0] masked_r;
  logic             out_valid_r;
  out_word_t        out_r;

  logic             accept;
  logic             draw_start;
  logic             mul_done;
  logic [DataW-1:0] product;
  logic [DataW-1:0] new_seed;
  logic [DataW-1:0] new_masked;
  logic             range_err;
  logic             div_start;
  logic             div_done;
  logic [DataW-1:0] remainder;

  assign accept     = start && (state_r == ST_IDLE);
  assign new_seed   = post_update(product, mode_r);
  assign new_masked = new_seed & width_mask(width_r);
  assign range_err  = (high_r <= low_r);

  // Seed multiply and span reduction units.
  mrg_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (draw_start),
    .operand (seed_r ^ XOR_IN_CONST),
    .done    (mul_done),
    .product (product)
  );

  mrg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (new_masked),
    .divisor   (high_r - low_r),
    .done      (div_done),
    .remainder (remainder)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.kind == KIND_DRAW)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_nxt = range_err ? ST_IDLE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Unit start strobes.
  always_comb begin
    draw_start = 1'b0;
    div_start  = 1'b0;
    unique case (state_r)
      ST_IDLE: draw_start = accept && (in_data.kind == KIND_DRAW);
      ST_MUL:  div_start  = mul_done && !range_err;
      ST_DIV:  ;
      default: ;
    endcase
  end

  // Control registers: state, mode, seed and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_UNIFORM;
      seed_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (accept && (in_data.kind == KIND_LOAD)) begin
        seed_r <= in_data.seed_value;
      end else if ((state_r == ST_MUL) && mul_done) begin
        seed_r <= new_seed;
      end
      if (accept && (in_data.kind != KIND_DRAW)) begin
        out_valid_r <= 1'b1;
      end else if ((state_r == ST_MUL) && mul_done && range_err) begin
        out_valid_r <= 1'b1;
      end else if ((state_r == ST_DIV) && div_done) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Draw operands and the result word.
  always_ff @(posedge clk) begin
    if (draw_start) begin
      width_r <= in_data.width_code;
      low_r   <= in_data.range_low;
      high_r  <= in_data.range_high;
    end
    if ((state_r == ST_MUL) && mul_done) begin
      masked_r <= new_masked;
    end
    if (accept && (in_data.kind != KIND_DRAW)) begin
      out_r.random_value <= (in_data.kind == KIND_LOAD) ? in_data.seed_value : seed_r;
      out_r.ranged_value <= '0;
      out_r.range_error  <= 1'b0;
    end else if ((state_r == ST_MUL) && mul_done && range_err) begin
      out_r.random_value <= new_masked;
      out_r.ranged_value <= low_r;
      out_r.range_error  <= 1'b1;
    end else if ((state_r == ST_DIV) && div_done) begin
      out_r.random_value <= masked_r;
      out_r.ranged_value <= remainder + low_r;
      out_r.range_error  <= 1'b0;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ src/mrg_mul.sv @@
// Bit-serial multiplier by the fixed update constant, modulo 2^64.
// One constant bit per cycle. Depends on mrg_pkg.
`default_nettype none

module mrg_mul (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [mrg_pkg::DataW-1:0] operand,
  output logic                           done,
  output logic [mrg_pkg::DataW-1:0]      product
);
  import mrg_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [DataW-1:0] x_r, x_nxt;
  logic [DataW-1:0] c_r, c_nxt;
  logic [DataW-1:0] acc_r, acc_nxt;

  // Shift-add step: add the shifted operand when the current constant bit is set.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    c_nxt    = c_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = operand;
      c_nxt    = MUL_CONST;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (c_r[0]) begin
        acc_nxt = acc_r + x_r;
      end
      x_nxt   = {x_r[DataW-2:0], 1'b0};
      c_nxt   = {1'b0, c_r[DataW-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(DataW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    c_r   <= c_nxt;
    acc_r <= acc_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

`default_nettype wire

@@ src/mrg_div.sv @@
// Radix-2 restoring modulo unit: one dividend bit per cycle.
// Gives the remainder of dividend by a nonzero divisor. Depends on mrg_pkg.
`default_nettype none

module mrg_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [mrg_pkg::DataW-1:0] dividend,
  input  wire logic [mrg_pkg::DataW-1:0] divisor,
  output logic                           done,
  output logic [mrg_pkg::DataW-1:0]      remainder
);
  import mrg_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [DataW-1:0] q_r, q_nxt;
  logic [DataW-1:0] d_r, d_nxt;
  logic [DataW-1:0] rem_r, rem_nxt;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;

  // Bring in the next dividend bit and subtract the divisor if it fits.
  assign trial = {rem_r, q_r[DataW-1]};
  assign diff  = trial - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      d_nxt    = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      q_nxt   = {q_r[DataW-2:0], 1'b0};
      rem_nxt = diff[DataW] ? trial[DataW-1:0] : diff[DataW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(DataW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the multiply-xor random generator.
// Depends on mrg_pkg and the mulxor_random_generator RTL; it keeps its own
// copy of the seed and mode to predict every result word.
`timescale 1ns / 100ps

module tb_top;
  import mrg_pkg::*;

  // Codes the package leaves unnamed.
  localparam logic [1:0] KIND_SPARE   = 2'd3;
  localparam logic [2:0] WC_FULL      = 3'd4;
  localparam logic       MODE_CYCLIC  = 1'b1;
  localparam logic [DataW-1:0] ALL_ONES = '1;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_TAIL  = 140;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_data = '0;
  logic      out_valid;
  out_word_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  // Shadow state of the generator.
  logic [DataW-1:0] seed_copy = '0;
  logic             mode_copy = MODE_UNIFORM;

  out_word_t   awaited_words[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          quiet_stretch = 1'b0;

  mulxor_random_generator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // One step of the seed sequence under the current mode.
  function automatic logic [DataW-1:0] next_seed(input logic [DataW-1:0] s);
    logic [DataW-1:0] p;
    logic [DataW-1:0] q;
    p = (s ^ XOR_IN_CONST) * MUL_CONST;
    if (mode_copy == MODE_CYCLIC) begin
      q = (p + ADD_CONST) ^ XOR_OUT_CONST;
    end else begin
      q = p;
      q[SwapAHi] = p[SwapALo];
      q[SwapALo] = p[SwapAHi];
      q[SwapBHi] = p[SwapBLo];
      q[SwapBLo] = p[SwapBHi];
    end
    return q;
  endfunction

  // Result word that an accepted input word must produce; updates the shadow seed.
  function automatic out_word_t predicted_word(input in_word_t w);
    out_word_t        r;
    logic [DataW-1:0] keep;
    r = '0;
    if (w.kind == KIND_DRAW) begin
      case (w.width_code)
        WC_BIT:  keep = 64'h1;
        WC_BYTE: keep = 64'hff;
        WC_HALF: keep = 64'hffff;
        WC_WORD: keep = 64'hffff_ffff;
        default: keep = ALL_ONES;
      endcase
      seed_copy = next_seed(seed_copy);
      r.random_value = seed_copy & keep;
      if (w.range_high <= w.range_low) begin
        r.ranged_value = w.range_low;
        r.range_error  = 1'b1;
      end else begin
        r.ranged_value = (r.random_value % (w.range_high - w.range_low)) + w.range_low;
      end
    end else begin
      if (w.kind == KIND_LOAD) seed_copy = w.seed_value;
      r.random_value = seed_copy;
    end
    return r;
  endfunction

  // Compare each result word with the oldest prediction.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid) begin
      if (awaited_words.size() == 0) begin
        mismatches = mismatches + 1;
        $display("%0t: result word with none expected: %h", $time, out_data);
      end else begin
        e = awaited_words.pop_front();
        if (out_data.random_value !== e.random_value) begin
          mismatches = mismatches + 1;
          $display("%0t: random_value expected %h actual %h", $time,
                   e.random_value, out_data.random_value);
        end
        if (out_data.ranged_value !== e.ranged_value) begin
          mismatches = mismatches + 1;
          $display("%0t: ranged_value expected %h actual %h", $time,
                   e.ranged_value, out_data.ranged_value);
        end
        if (out_data.range_error !== e.range_error) begin
          mismatches = mismatches + 1;
          $display("%0t: range_error expected %b actual %b", $time,
                   e.range_error, out_data.range_error);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic in_word_t make_word(input logic [1:0] kind,
                                         input logic [DataW-1:0] seed,
                                         input logic [2:0] wc,
                                         input logic [DataW-1:0] lo,
                                         input logic [DataW-1:0] hi);
    in_word_t w;
    w.kind       = kind;
    w.seed_value = seed;
    w.width_code = wc;
    w.range_low  = lo;
    w.range_high = hi;
    return w;
  endfunction

  function automatic logic [DataW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random input word: mostly draws, with a spread of range shapes.
  function automatic in_word_t random_word();
    in_word_t         w;
    int unsigned      pick;
    logic [DataW-1:0] t;
    pick = $urandom_range(0, 99);
    if (pick < 60) w.kind = KIND_DRAW;
    else if (pick < 75) w.kind = KIND_LOAD;
    else if (pick < 92) w.kind = KIND_READ;
    else w.kind = KIND_SPARE;
    case ($urandom_range(0, 9))
      0: w.seed_value = '0;
      1: w.seed_value = ALL_ONES;
      default: w.seed_value = rand64();
    endcase
    w.width_code = 3'($urandom_range(0, 7));
    w.range_low  = rand64();
    w.range_high = rand64();
    case ($urandom_range(0, 9))
      0: w.range_high = w.range_low;
      1: begin
        if (w.range_high > w.range_low) begin
          t = w.range_high;
          w.range_high = w.range_low;
          w.range_low = t;
        end
      end
      2, 3, 4: begin
        w.range_low  = {32'h0, $urandom} >> $urandom_range(0, 31);
        w.range_high = w.range_low + $urandom_range(1, 300);
      end
      8: w.range_low = '0;
      9: w.range_high = ALL_ONES;
      default: begin
        if (w.range_high < w.range_low) begin
          t = w.range_high;
          w.range_high = w.range_low;
          w.range_low = t;
        end
      end
    endcase
    return w;
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input in_word_t w);
    start   <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    awaited_words.push_back(predicted_word(w));
  endtask

  task automatic idle_gap(input int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Mostly short gaps, a few long ones, none during a quiet stretch.
  function automatic int unsigned random_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (quiet_stretch || pick < 65) return 0;
    if (pick < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 70);
  endfunction

  // Hold off the sender until every expected word has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_words.size() != 0) @(posedge clk);
  endtask

  // Write the update mode while the block is idle.
  task automatic set_mode(input logic m);
    drain();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mode_copy = m;
  endtask

  // Directed words in uniform mode: reads after reset, every width code,
  // empty and inverted ranges, unit spans and the seed that zeroes the product.
  task automatic test_directed_uniform();
    int unsigned c;
    send_word(make_word(KIND_READ, ALL_ONES, WC_FULL, '0, '0));
    send_word(make_word(KIND_SPARE, ALL_ONES, WC_FULL, ALL_ONES, ALL_ONES));
    send_word(make_word(KIND_DRAW, '0, WC_BIT, '0, 64'd1));
    for (c = 1; c < 8; c++) begin
      send_word(make_word(KIND_DRAW, '0, c[2:0], '0, ALL_ONES));
      idle_gap(c % 3);
    end
    send_word(make_word(KIND_DRAW, '0, WC_FULL, 64'd5, 64'd5));
    send_word(make_word(KIND_DRAW, '0, WC_FULL, ALL_ONES, '0));
    send_word(make_word(KIND_DRAW, '0, WC_FULL, ALL_ONES - 1, ALL_ONES));
    send_word(make_word(KIND_LOAD, ALL_ONES, WC_BIT, '0, '0));
    send_word(make_word(KIND_READ, '0, WC_BIT, '0, '0));
    send_word(make_word(KIND_DRAW, '0, WC_FULL, '0, 64'd3));
    send_word(make_word(KIND_LOAD, '0, WC_FULL, ALL_ONES, ALL_ONES));
    send_word(make_word(KIND_DRAW, '0, WC_WORD, 64'd1, ALL_ONES));
    send_word(make_word(KIND_LOAD, XOR_IN_CONST, WC_FULL, '0, '0));
    send_word(make_word(KIND_DRAW, '0, WC_FULL, '0, ALL_ONES));
  endtask

  // Directed words in cyclic mode, including the zero product case.
  task automatic test_directed_cyclic();
    set_mode(MODE_CYCLIC);
    send_word(make_word(KIND_LOAD, XOR_IN_CONST, WC_FULL, '0, '0));
    send_word(make_word(KIND_DRAW, '0, WC_FULL, 64'd7, 64'd1000));
    send_word(make_word(KIND_READ, '0, WC_FULL, '0, '0));
  endtask

  // Random words in one mode, with a full pause halfway through.
  task automatic test_random(input logic m, input int unsigned count);
    int unsigned i;
    set_mode(m);
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) quiet_stretch = ($urandom_range(0, 2) == 0);
      if (i == count / 2) drain();
      send_word(random_word());
      idle_gap(random_gap());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_uniform();
    test_directed_cyclic();
    test_random(MODE_UNIFORM, 240);
    test_random(MODE_CYCLIC, 240);
    test_random(MODE_CYCLIC, 230);
    test_random(MODE_UNIFORM, 240);
    drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0 && awaited_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
